FILE: sv/assert_macros.svh
// Assertion macros for RTL; GTG_ASSERT also needs rst_ni, both need clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define GTG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define GTG_ASSERT(lbl, prop)
`define GTG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: sv/gtg_pkg.sv
package gtg_pkg;

  localparam int TARGET_DEPTH      = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANG_TABLE_LEN     = 24;
  localparam int ITER = (CORDIC_ITERATIONS < ANG_TABLE_LEN) ? CORDIC_ITERATIONS
                                                            : ANG_TABLE_LEN;
  localparam int IDX_W = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam int CNT_W = $clog2(TARGET_DEPTH + 1);

  localparam int COORD_W = 24;
  localparam int ERR_W   = 25;
  localparam int SUM_W   = 50;
  localparam int DIST_W  = 25;
  localparam int CW      = 44;
  localparam int ZW      = 20;
  localparam int ANG_W   = 15;
  localparam int IDXO_W  = 5;
  localparam int GAIN_W  = 13;
  localparam int THR_W   = 23;
  localparam int MEM_W   = 2 * COORD_W;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [16:0]   INV_K_Q16   = 17'sd39797;
  localparam int OMEGA_LIMIT = 12868;
  localparam int POS_MAX     = 8388607;
  localparam int POS_MIN     = -8388608;

  localparam logic [1:0] CFG_LINEAR_GAIN  = 2'd0;
  localparam logic [1:0] CFG_ANGULAR_GAIN = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP    = 2'd2;
  localparam logic [1:0] CFG_REACH_THR    = 2'd3;

  localparam logic [0:0] ACT_LOAD = 1'b0;
  localparam logic [0:0] ACT_TICK = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] linear_gain;
    logic [GAIN_W-1:0] angular_gain;
    logic [GAIN_W-1:0] time_step;
    logic [THR_W-1:0]  reach_threshold;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [MEM_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:    atan_q16 = 20'sd51472;
      5'd1:    atan_q16 = 20'sd30385;
      5'd2:    atan_q16 = 20'sd16055;
      5'd3:    atan_q16 = 20'sd8150;
      5'd4:    atan_q16 = 20'sd4091;
      5'd5:    atan_q16 = 20'sd2047;
      5'd6:    atan_q16 = 20'sd1024;
      5'd7:    atan_q16 = 20'sd512;
      5'd8:    atan_q16 = 20'sd256;
      5'd9:    atan_q16 = 20'sd128;
      5'd10:   atan_q16 = 20'sd64;
      5'd11:   atan_q16 = 20'sd32;
      5'd12:   atan_q16 = 20'sd16;
      5'd13:   atan_q16 = 20'sd8;
      5'd14:   atan_q16 = 20'sd4;
      5'd15:   atan_q16 = 20'sd2;
      5'd16:   atan_q16 = 20'sd1;
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

FILE: sv/gtg_if.sv
interface gtg_in_if;
  import gtg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [COORD_W-1:0]  target_x;
  logic signed [COORD_W-1:0]  target_y;
  modport source (output valid, action, target_x, target_y, input ready);
  modport sink (input valid, action, target_x, target_y, output ready);
endinterface

interface gtg_out_if;
  import gtg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] linear_speed;
  logic signed [ANG_W-1:0]   angular_speed;
  logic [IDXO_W-1:0]         target_index;
  logic                      reached;
  logic                      all_done;
  logic                      last;
  modport source (output valid, linear_speed, angular_speed, target_index, reached,
                  all_done, last, input ready);
  modport sink (input valid, linear_speed, angular_speed, target_index, reached,
                all_done, last, output ready);
endinterface

FILE: sv/gtg_ram.sv
module gtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/gtg_engine.sv
`include "assert_macros.svh"
module gtg_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gtg_pkg::cfg_t         cfg_i,
  gtg_in_if.sink                in_i,
  gtg_out_if.source             out_o,
  output gtg_pkg::mem_req_t     mem_req_o,
  input  logic [gtg_pkg::MEM_W-1:0] mem_rdata_i
);
  import gtg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_SQ1  = 4'd2;
  localparam logic [3:0] S_SQ2  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_LIN  = 4'd5;
  localparam logic [3:0] S_ANG  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_STOP = 4'd8;
  localparam logic [3:0] S_ROTI = 4'd9;
  localparam logic [3:0] S_ROT  = 4'd10;
  localparam logic [3:0] S_MULX = 4'd11;
  localparam logic [3:0] S_MULY = 4'd12;
  localparam logic [3:0] S_UPD  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  localparam logic [4:0] ROOT_LAST = 5'(SUM_W / 2 - 1);
  localparam logic [4:0] ITER_LAST = 5'(ITER - 1);

  logic [3:0]              st_q, st_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, idx_q, idx_d;
  logic signed [COORD_W-1:0] posx_q, posx_d, posy_q, posy_d;
  logic                    ov_q, ov_d;
  logic signed [ERR_W-1:0] ex_q, ey_q;
  logic [SUM_W-1:0]        n_q;
  logic [SUM_W:0]          r_q;
  logic [4:0]              k_q, it_q;
  logic signed [CW-1:0]    cx_q, cy_q;
  logic signed [ZW-1:0]    cz_q, theta_q;
  logic                    zero_q;
  logic [DIST_W-1:0]       dist_q;
  logic signed [COORD_W-1:0] lin_q;
  logic signed [ANG_W-1:0] ang_q;
  logic signed [29:0]      prod_q;

  logic signed [COORD_W-1:0] o_lin_q;
  logic signed [ANG_W-1:0] o_ang_q;
  logic [IDXO_W-1:0]       o_idx_q;
  logic                    o_reached_q, o_done_q, o_last_q;

  logic acc, out_free, load_out, reach;
  logic signed [COORD_W-1:0] l_lin;
  logic signed [ANG_W-1:0] l_ang;
  logic l_reached, l_done, l_last;

  assign acc      = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign reach    = {2'b00, cfg_i.reach_threshold} > dist_q;

  assign in_i.ready           = (st_q == S_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.linear_speed   = o_lin_q;
  assign out_o.angular_speed  = o_ang_q;
  assign out_o.target_index   = o_idx_q;
  assign out_o.reached        = o_reached_q;
  assign out_o.all_done       = o_done_q;
  assign out_o.last           = o_last_q;

  assign mem_req_o.we    = acc && (in_i.action == ACT_LOAD) &&
                           (cnt_q < CNT_W'(TARGET_DEPTH));
  assign mem_req_o.waddr = cnt_q[IDX_W-1:0];
  assign mem_req_o.wdata = {in_i.target_x, in_i.target_y};
  assign mem_req_o.raddr = idx_q[IDX_W-1:0];

  // Shared CORDIC step: vectoring steers on the sign of y, rotation on z.
  logic signed [CW-1:0] xs, ys, step_x, step_y;
  logic signed [ZW-1:0] step_z, atan_i;
  logic                 neg_dir;
  always_comb begin
    xs     = cx_q >>> it_q;
    ys     = cy_q >>> it_q;
    atan_i = atan_q16(it_q);
    neg_dir = (st_q == S_ROT) ? cz_q[ZW-1] : !cy_q[CW-1];
    if (neg_dir) begin
      step_x = cx_q + ys;
      step_y = cy_q - xs;
      step_z = cz_q + atan_i;
    end else begin
      step_x = cx_q - ys;
      step_y = cy_q + xs;
      step_z = cz_q - atan_i;
    end
  end

  // One digit of the integer square root per cycle.
  logic [SUM_W:0] b_val, rb;
  logic [SUM_W-1:0] root_n;
  logic [SUM_W:0] root_r;
  always_comb begin
    b_val = (SUM_W + 1)'(1) << {k_q, 1'b0};
    rb    = r_q + b_val;
    if ({1'b0, n_q} >= rb) begin
      root_n = n_q - rb[SUM_W-1:0];
      root_r = (r_q >> 1) + b_val;
    end else begin
      root_n = n_q;
      root_r = r_q >> 1;
    end
  end

  logic signed [ERR_W-1:0] ex_c, ey_c;
  logic signed [CW-1:0]    vx0, vy0, rx0;
  logic signed [49:0]      sq;
  logic [37:0]             lin_prod;
  logic signed [ZW-1:0]    theta_c;
  logic signed [33:0]      ang_prod;
  logic signed [17:0]      ang_sh;
  logic signed [57:0]      ts_prod;
  logic signed [30:0]      pos_sum;
  logic signed [COORD_W-1:0] pos_sat;
  logic signed [CW-1:0]    mul_src;
  logic signed [COORD_W-1:0] pos_src;

  always_comb begin
    ex_c = {mem_rdata_i[MEM_W-1], mem_rdata_i[MEM_W-1:COORD_W]} - {posx_q[COORD_W-1], posx_q};
    ey_c = {mem_rdata_i[COORD_W-1], mem_rdata_i[COORD_W-1:0]} - {posy_q[COORD_W-1], posy_q};
    vx0  = CW'(ex_q) <<< 16;
    vy0  = CW'(ey_q) <<< 16;
    sq   = (st_q == S_SQ1) ? ex_q * ex_q : ey_q * ey_q;
    lin_prod = cfg_i.linear_gain * dist_q;
    // A zero error has a bearing of zero, whatever the vectoring left in z.
    theta_c  = zero_q ? '0 : cz_q;
    ang_prod = $signed({1'b0, cfg_i.angular_gain}) * theta_c;
    ang_sh   = 18'(ang_prod >>> 16);
    rx0      = CW'(lin_q) * CW'(INV_K_Q16);
    mul_src  = (st_q == S_MULX) ? cx_q : cy_q;
    ts_prod  = mul_src * $signed({1'b0, cfg_i.time_step});
    pos_src  = (st_q == S_MULY) ? posx_q : posy_q;
    pos_sum  = 31'(pos_src) + 31'(prod_q);
    if (pos_sum > 31'(POS_MAX)) begin
      pos_sat = COORD_W'(POS_MAX);
    end else if (pos_sum < 31'(POS_MIN)) begin
      pos_sat = COORD_W'(POS_MIN);
    end else begin
      pos_sat = pos_sum[COORD_W-1:0];
    end
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    posx_d = posx_q;
    posy_d = posy_q;
    ov_d   = ov_q && !out_o.ready;
    load_out  = 1'b0;
    l_lin     = lin_q;
    l_ang     = ang_q;
    l_reached = 1'b0;
    l_done    = 1'b0;
    l_last    = 1'b1;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          if (in_i.action == ACT_LOAD) begin
            if (mem_req_o.we) begin
              cnt_d = cnt_q + 1'b1;
            end
          end else if (idx_q >= cnt_q) begin
            st_d = S_DONE;
          end else begin
            st_d = S_ERR;
          end
        end
      end
      S_ERR:  st_d = S_SQ1;
      S_SQ1:  st_d = S_SQ2;
      S_SQ2:  st_d = S_ROOT;
      S_ROOT: if (k_q == '0) st_d = S_LIN;
      S_LIN:  st_d = S_ANG;
      S_ANG:  st_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          l_last   = !reach;
          st_d     = reach ? S_STOP : S_ROTI;
        end
      end
      S_STOP: begin
        if (out_free) begin
          load_out  = 1'b1;
          l_lin     = '0;
          l_ang     = '0;
          l_reached = 1'b1;
          l_done    = (idx_q + 1'b1) == cnt_q;
          posx_d    = '0;
          posy_d    = '0;
          idx_d     = idx_q + 1'b1;
          st_d      = S_IDLE;
        end
      end
      S_ROTI: st_d = S_ROT;
      S_ROT:  if (it_q == ITER_LAST) st_d = S_MULX;
      S_MULX: st_d = S_MULY;
      S_MULY: begin
        posx_d = pos_sat;
        st_d   = S_UPD;
      end
      S_UPD: begin
        posy_d = pos_sat;
        st_d   = S_IDLE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          l_lin    = '0;
          l_ang    = '0;
          l_done   = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (load_out) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      posx_q <= '0;
      posy_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      posx_q <= posx_d;
      posy_q <= posy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_lin_q     <= l_lin;
      o_ang_q     <= l_ang;
      o_idx_q     <= IDXO_W'(idx_q);
      o_reached_q <= l_reached;
      o_done_q    <= l_done;
      o_last_q    <= l_last;
    end
    case (st_q)
      S_ERR: begin
        ex_q <= ex_c;
        ey_q <= ey_c;
      end
      S_SQ1: begin
        n_q    <= SUM_W'(sq);
        zero_q <= (ex_q == '0) && (ey_q == '0);
        it_q   <= '0;
        if (ex_q[ERR_W-1]) begin
          if (!ey_q[ERR_W-1]) begin
            cx_q <= vy0;
            cy_q <= -vx0;
            cz_q <= HALF_PI_Q16;
          end else begin
            cx_q <= -vy0;
            cy_q <= vx0;
            cz_q <= -HALF_PI_Q16;
          end
        end else begin
          cx_q <= vx0;
          cy_q <= vy0;
          cz_q <= '0;
        end
      end
      S_SQ2: begin
        n_q <= n_q + SUM_W'(sq);
        r_q <= '0;
        k_q <= ROOT_LAST;
      end
      S_ROOT: begin
        n_q <= root_n;
        r_q <= root_r;
        k_q <= k_q - 1'b1;
        if (k_q == '0) begin
          dist_q <= root_r[DIST_W-1:0];
        end
        if (it_q < 5'(ITER)) begin
          cx_q <= step_x;
          cy_q <= step_y;
          cz_q <= step_z;
          it_q <= it_q + 1'b1;
        end
      end
      S_LIN: begin
        if (lin_prod[37:12] > 26'(POS_MAX)) begin
          lin_q <= COORD_W'(POS_MAX);
        end else begin
          lin_q <= lin_prod[35:12];
        end
      end
      S_ANG: begin
        theta_q <= theta_c;
        if (ang_sh > 18'sd12868) begin
          ang_q <= ANG_W'(OMEGA_LIMIT);
        end else if (ang_sh < -18'sd12868) begin
          ang_q <= ANG_W'(-OMEGA_LIMIT);
        end else begin
          ang_q <= ang_sh[ANG_W-1:0];
        end
      end
      S_ROTI: begin
        it_q <= '0;
        if (theta_q > HALF_PI_Q16) begin
          cx_q <= '0;
          cy_q <= rx0;
          cz_q <= theta_q - HALF_PI_Q16;
        end else if (theta_q < -HALF_PI_Q16) begin
          cx_q <= '0;
          cy_q <= -rx0;
          cz_q <= theta_q + HALF_PI_Q16;
        end else begin
          cx_q <= rx0;
          cy_q <= '0;
          cz_q <= theta_q;
        end
      end
      S_ROT: begin
        cx_q <= step_x;
        cy_q <= step_y;
        cz_q <= step_z;
        it_q <= it_q + 1'b1;
      end
      S_MULX, S_MULY: prod_q <= 30'(ts_prod >>> 28);
      default: begin
      end
    endcase
  end

  `GTG_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(TARGET_DEPTH))
  `GTG_ASSERT(a_idx_bound, idx_q <= cnt_q)
  `GTG_ASSERT(a_tick_busy, (acc && in_i.action == ACT_TICK) |=> !in_i.ready)
  `GTG_ASSERT(a_stop_zero, (ov_q && o_reached_q) |-> (o_lin_q == '0 && o_last_q))
endmodule

FILE: sv/go_to_goal_waypoint_controller_top.sv
// Go-to-goal waypoint follower. A load item gives no result. A tick forms the
// error to the current target and runs the square root with the vectoring CORDIC
// beside it, then emits a command; unless the target is reached, the 16-step
// rotation CORDIC moves the position, else a stop command follows. On an
// exhausted table a tick gives only a done command; receiver stalls lengthen a tick.
// A reset clears position, index, target count and the output slot, loads defaults.
module go_to_goal_waypoint_controller_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gtg_in_if.sink                     in_i,
  gtg_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [gtg_pkg::THR_W-1:0]  cfg_data_i
);
  import gtg_pkg::*;

  cfg_t             cfg_q, cfg_d;
  mem_req_t         mem_req;
  logic [MEM_W-1:0] mem_rdata;

  // Users write registers only while the block is idle; the block does not check.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINEAR_GAIN:  cfg_d.linear_gain     = cfg_data_i[GAIN_W-1:0];
        CFG_ANGULAR_GAIN: cfg_d.angular_gain    = cfg_data_i[GAIN_W-1:0];
        CFG_TIME_STEP:    cfg_d.time_step       = cfg_data_i[GAIN_W-1:0];
        CFG_REACH_THR:    cfg_d.reach_threshold = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain     <= GAIN_W'(2048);
      cfg_q.angular_gain    <= GAIN_W'(2048);
      cfg_q.time_step       <= GAIN_W'(410);
      cfg_q.reach_threshold <= THR_W'(410);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Target table: x in the upper half of each word, y in the lower half.
  gtg_ram #(
    .WIDTH(MEM_W),
    .DEPTH(TARGET_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  gtg_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .out_o      (out_o),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );
endmodule

FILE: tb/sv/gtg_checker.sv
// Watches the load/tick channel, the command channel and the register port.
// Holds its own copy of the follower state, predicts the commands each item
// causes and compares every command with the oldest prediction.
module gtg_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gtg_in_if    in_if,
  gtg_out_if   out_if,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [gtg_pkg::THR_W-1:0] cfg_data_i,
  output int   fail_count,
  output int   pending
);
  import gtg_pkg::*;

  typedef struct {
    logic [23:0] lin;
    logic [14:0] ang;
    logic [4:0]  idx;
    logic        reached;
    logic        all_done;
    logic        last;
  } cmd_t;

  localparam longint ArcTab [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint QuarterTurn = 102944;
  localparam longint InvGain     = 39797;

  cmd_t   cmd_q[$];
  longint wp_x [16];
  longint wp_y [16];
  int     wp_count;
  int     wp_index;
  longint pos_x, pos_y;
  longint lin_gain, ang_gain, step_dt, reach_thr;
  int     n_fail;

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint heading(input longint ex, input longint ey);
    longint x, y, z, t, xs, ys;
    x = ex * 65536;
    y = ey * 65536;
    z = 0;
    if (ex == 0 && ey == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QuarterTurn;
      end else begin
        t = x; x = -y; y = t; z = -QuarterTurn;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ArcTab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ArcTab[i];
      end
    end
    return z;
  endfunction

  task automatic polar_to_xy(input longint v, input longint th,
                             output longint cx, output longint cy);
    longint x, y, z, t, xs, ys;
    x = v * InvGain;
    y = 0;
    z = th;
    if (z > QuarterTurn) begin
      t = x; x = -y; y = t; z = z - QuarterTurn;
    end else if (z < -QuarterTurn) begin
      t = x; x = y; y = -t; z = z + QuarterTurn;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ArcTab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ArcTab[i];
      end
    end
    cx = x;
    cy = y;
  endtask

  function automatic longint sat24(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic cmd_t make_cmd(input longint lin, input longint ang, input int idx,
                                    input logic rch, input logic dn, input logic lst);
    cmd_t c;
    c.lin      = lin[23:0];
    c.ang      = ang[14:0];
    c.idx      = idx[4:0];
    c.reached  = rch;
    c.all_done = dn;
    c.last     = lst;
    return c;
  endfunction

  // Appends one predicted command at the tail of the queue.
  function automatic void add_cmd(input cmd_t c);
    cmd_q = {cmd_q, c};
  endfunction

  task automatic follow_step(input logic act, input logic signed [23:0] tx,
                             input logic signed [23:0] ty);
    longint ex, ey, span, th, lin, ang, cx, cy;
    if (act == ACT_LOAD) begin
      if (wp_count < TARGET_DEPTH) begin
        wp_x[wp_count] = longint'(tx);
        wp_y[wp_count] = longint'(ty);
        wp_count++;
      end
      return;
    end
    if (wp_index >= wp_count) begin
      add_cmd(make_cmd(0, 0, wp_index, 1'b0, 1'b1, 1'b1));
      return;
    end
    ex   = wp_x[wp_index] - pos_x;
    ey   = wp_y[wp_index] - pos_y;
    span = root_floor(longint'(ex * ex + ey * ey));
    th   = heading(ex, ey);
    lin  = (lin_gain * span) >>> 12;
    if (lin > POS_MAX) lin = POS_MAX;
    ang  = (ang_gain * th) >>> 16;
    if (ang > OMEGA_LIMIT) ang = OMEGA_LIMIT;
    if (ang < -OMEGA_LIMIT) ang = -OMEGA_LIMIT;
    if (span < reach_thr) begin
      add_cmd(make_cmd(lin, ang, wp_index, 1'b0, 1'b0, 1'b0));
      add_cmd(make_cmd(0, 0, wp_index, 1'b1, (wp_index + 1 == wp_count), 1'b1));
      pos_x = 0;
      pos_y = 0;
      wp_index++;
    end else begin
      add_cmd(make_cmd(lin, ang, wp_index, 1'b0, 1'b0, 1'b1));
      polar_to_xy(lin, th, cx, cy);
      pos_x = sat24(pos_x + ((cx * step_dt) >>> 28));
      pos_y = sat24(pos_y + ((cy * step_dt) >>> 28));
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t want;
    if (!rst_ni) begin
      cmd_q.delete();
      wp_count  = 0;
      wp_index  = 0;
      pos_x     = 0;
      pos_y     = 0;
      lin_gain  = 2048;
      ang_gain  = 2048;
      step_dt   = 410;
      reach_thr = 410;
      n_fail    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINEAR_GAIN:  lin_gain  = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_ANGULAR_GAIN: ang_gain  = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_TIME_STEP:    step_dt   = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_REACH_THR:    reach_thr = longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (cmd_q.size() == 0) begin
          report("unexpected command", 0, 0);
        end else begin
          want = cmd_q.pop_front();
          if (out_if.linear_speed !== want.lin)
            report("linear_speed", out_if.linear_speed, want.lin);
          if (out_if.angular_speed !== want.ang)
            report("angular_speed", out_if.angular_speed, want.ang);
          if (out_if.target_index !== want.idx)
            report("target_index", out_if.target_index, want.idx);
          if (out_if.reached !== want.reached)
            report("reached", out_if.reached, want.reached);
          if (out_if.all_done !== want.all_done)
            report("all_done", out_if.all_done, want.all_done);
          if (out_if.last !== want.last)
            report("last", out_if.last, want.last);
        end
      end
      if (in_if.valid && in_if.ready)
        follow_step(in_if.action, in_if.target_x, in_if.target_y);
    end
    pending    <= cmd_q.size();
    fail_count <= n_fail;
  end

endmodule

FILE: tb/sv/tb_go_to_goal_waypoint_controller_top.sv
// Stimulus and verdict for the waypoint follower. The checker beside the block
// predicts and compares; this module only makes items, idles both sides, writes
// the registers between phases and decides pass or fail.
module tb_go_to_goal_waypoint_controller_top;
  import gtg_pkg::*;

  // Allow a generous margin over one tick for the quiet time before a register
  // write and at the end of the run.
  localparam int SETTLE_CYCLES = 120;
  // Cycles without any accepted item before the run is declared hung. The
  // slowest legal gap is one tick plus a long receiver stall, far below this.
  localparam int HANG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [THR_W-1:0] cfg_data;
  int fail_count;
  int pending;
  int send_idle;
  int recv_stall;
  int quiet_cycles = 0;

  gtg_in_if  in_if ();
  gtg_out_if out_if ();

  go_to_goal_waypoint_controller_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gtg_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random with the chance set by the current phase.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  // The watchdog restarts whenever an item moves on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offers one item and holds it until it is accepted. The sender may then
  // idle at random; valid is always left in a defined state.
  task automatic send_item(input logic act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.target_x <= x;
    in_if.target_y <= y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every predicted command has come out, then
  // lets the block settle, since a load in flight has no command to wait for.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [THR_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int lg, input int ag, input int ts, input int thr);
    drain();
    write_reg(CFG_LINEAR_GAIN, THR_W'(lg));
    write_reg(CFG_ANGULAR_GAIN, THR_W'(ag));
    write_reg(CFG_TIME_STEP, THR_W'(ts));
    write_reg(CFG_REACH_THR, THR_W'(thr));
  endtask

  function automatic logic [COORD_W-1:0] near_coord();
    return COORD_W'($urandom_range(32768) - 16384);
  endfunction

  // Random phase. Ticks dominate so that the follower is driven toward each
  // target; loads are rare so that the small table fills over the whole run.
  // Most targets lie within 16384 of the origin so they can actually be reached.
  task automatic run_phase(input int n, input int mode, input int pause_at);
    int r;
    logic [COORD_W-1:0] x, y;
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 87; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 87; end
      default: begin send_idle = 8; recv_stall = 8; end
    endcase
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) begin
        // The sender holds off until every command so far has arrived.
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 5) begin
        if ($urandom_range(3) == 0) begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end else begin
          x = near_coord();
          y = near_coord();
        end
        send_item(ACT_LOAD, x, y);
      end else begin
        send_item(ACT_TICK, COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_LOAD;
    in_if.target_x <= '0;
    in_if.target_y <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_LINEAR_GAIN;
    cfg_data       <= '0;
    send_idle      = 0;
    recv_stall     = 0;
    rst_n          = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings. A tick on an empty table gives a
    // done command; a target at the origin has zero error and is reached at
    // once, which also marks the whole table done.
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_LOAD, '0, '0);
    send_item(ACT_TICK, '1, '1);
    send_item(ACT_TICK, '0, '0);
    // Negative-x targets take the quarter-turn pre-rotation for both signs of y.
    send_item(ACT_LOAD, 24'h800000, 24'h7fffff);
    send_item(ACT_LOAD, 24'h7fffff, 24'h800000);
    send_item(ACT_LOAD, 24'hffc000, 24'hffe000);
    repeat (3) send_item(ACT_TICK, '0, '0);

    // Gains at their maximum, threshold at its maximum: the far target is
    // overshot or reached in a handful of ticks.
    set_regs(8191, 8191, 8191, 8388607);
    repeat (4) send_item(ACT_TICK, '0, '0);
    // Unity linear gain and step: one tick lands close to the target.
    set_regs(4096, 4096, 4096, 4096);
    repeat (4) send_item(ACT_TICK, '0, '0);
    // Everything zero: the follower never moves and never counts a target reached.
    set_regs(0, 0, 0, 0);
    repeat (3) send_item(ACT_TICK, '0, '0);

    // Random phases, each under its own register settings and idling mode.
    set_regs(2048, 2048, 410, 410);
    run_phase(70, 0, -1);
    set_regs(4096, 4096, 4096, 4096);
    run_phase(70, 1, -1);
    set_regs(3000, 1000, 2000, 20000);
    run_phase(70, 2, -1);
    set_regs(4096, 2048, 1024, 8192);
    run_phase(70, 3, 35);
    set_regs($urandom_range(4096), $urandom_range(4096), $urandom_range(4096),
             $urandom_range(40000));
    run_phase(70, 0, -1);
    set_regs(0, 0, 0, 0);
    run_phase(40, 1, -1);
    set_regs(8191, 8191, 8191, 8388607);
    run_phase(40, 2, -1);
    set_regs($urandom_range(4096), $urandom_range(4096), $urandom_range(4096),
             $urandom_range(8388607));
    run_phase(80, 3, -1);

    // Every item is in; wait for the last commands and a quiet tail.
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
